[rtl/assert_macros.svh]
// Assertion helpers shared by the stick shaping RTL.
// Each macro expands to one concurrent assertion clocked on clk_i.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checked only while rst_ni is high.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every clock edge, during reset as well.
`define ASSERT_ALW(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`endif

[rtl/jdr_pkg.sv]
// Shared constants, types and elaboration-time functions for the stick shaping core.
// Used by jdr_shape and joystick_deadzone_response_core. Depends on nothing else.
package jdr_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int FRACTION_BITS = 14;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  localparam logic [CFG_IDX_W-1:0] REG_RADIAL_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DZ    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_DZ    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT    = 2'd3;

  localparam logic [15:0] RESET_EXPONENT = 16'd4096;

  localparam int DIV_STEPS  = 32;
  localparam int NORM_STEPS = 4;
  localparam int LOG_STEPS  = 28;
  localparam int EXP_STEPS  = 28;
  localparam int LANE_LAT   = 1 + DIV_STEPS + NORM_STEPS + LOG_STEPS + 2 + EXP_STEPS + 1;

  typedef struct packed {
    logic [15:0] inner;
    logic [16:0] start;
    logic [15:0] expo;
  } shape_cfg_t;

  function automatic logic [31:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bw;
    int i;
    rem = v;
    res = '0;
    bw  = 64'd1 << 62;
    for (i = 0; i < 32; i++) begin
      if (rem >= res + bw) begin
        rem = rem - (res + bw);
        res = (res >> 1) + bw;
      end else begin
        res = res >> 1;
      end
      bw = bw >> 2;
    end
    return res[31:0];
  endfunction

  // Factor 2^(-2^-k) in Q0.32, built by k floor square roots starting from one half.
  function automatic logic [31:0] exp_factor(input int k);
    logic [63:0] c;
    int j;
    c = 64'd1 << 31;
    for (j = 0; j < k; j++) begin
      c = {32'd0, isqrt64(c << 32)};
    end
    return c[31:0];
  endfunction

endpackage

[rtl/jdr_shape.sv]
// Pipelined length shaping lane: dead zone compare, ratio divider, log2, exponent
// product and exp2 product chain. Uses jdr_pkg for stage counts and the factor table.
module jdr_shape #(
  parameter int LEN_W = 18
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  jdr_pkg::shape_cfg_t cfg_i,
  input  logic [LEN_W-1:0]   len_i,
  output logic [32:0]        shaped_o
);
  import jdr_pkg::*;

  localparam int FLAG_LEN = LANE_LAT - 1;
  localparam int CW = (LEN_W > 17) ? LEN_W : 17;

  typedef struct packed {
    logic zero;
    logic one;
  } flags_t;

  flags_t      flags_q   [FLAG_LEN];
  logic [16:0] div_rem_q [DIV_STEPS+1];
  logic [31:0] div_quo_q [DIV_STEPS+1];
  logic [31:0] nrm_man_q [NORM_STEPS];
  logic [3:0]  nrm_lz_q  [NORM_STEPS];
  logic [31:0] log_man_q [LOG_STEPS];
  logic [27:0] log_frac_q[LOG_STEPS];
  logic [3:0]  log_lz_q  [LOG_STEPS];
  logic [32:0] len_q;
  logic [36:0] pow_q;
  logic [48:0] pow_prod;
  logic [32:0] exp_r_q   [EXP_STEPS];
  logic [36:0] exp_pow_q [EXP_STEPS];
  logic [32:0] shaped_q;
  logic [16:0] divisor;
  logic [CW-1:0] len_ext;
  logic [CW-1:0] diff;
  logic        zero_c;
  logic        one_c;

  assign divisor = cfg_i.start - {1'b0, cfg_i.inner};
  assign len_ext = CW'(len_i);
  assign diff    = len_ext - CW'(cfg_i.inner);
  assign zero_c  = len_ext <= CW'(cfg_i.inner);
  assign one_c   = len_ext >= CW'(cfg_i.start);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flags_q[0]   <= {zero_c, one_c};
      div_rem_q[0] <= diff[16:0];
      div_quo_q[0] <= '0;
    end
  end

  for (genvar k = 1; k < FLAG_LEN; k++) begin : g_flag
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        flags_q[k] <= flags_q[k-1];
      end
    end
  end

  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
    logic [17:0] shl;
    logic        ge;
    assign shl = {div_rem_q[j-1], 1'b0};
    assign ge  = shl >= {1'b0, divisor};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        div_rem_q[j] <= ge ? 17'(shl - {1'b0, divisor}) : shl[16:0];
        div_quo_q[j] <= {div_quo_q[j-1][30:0], ge};
      end
    end
  end

  for (genvar s = 0; s < NORM_STEPS; s++) begin : g_nrm
    localparam int SH = 8 >> s;
    logic [31:0] man_in;
    logic [3:0]  lz_in;
    logic        top0;
    if (s == 0) begin : g_first
      assign man_in = div_quo_q[DIV_STEPS];
      assign lz_in  = '0;
    end else begin : g_next
      assign man_in = nrm_man_q[s-1];
      assign lz_in  = nrm_lz_q[s-1];
    end
    assign top0 = man_in[31 -: SH] == '0;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nrm_man_q[s] <= top0 ? (man_in << SH) : man_in;
        nrm_lz_q[s]  <= top0 ? (lz_in + 4'(SH)) : lz_in;
      end
    end
  end

  for (genvar i = 0; i < LOG_STEPS; i++) begin : g_log
    logic [31:0] man_in;
    logic [27:0] frac_in;
    logic [3:0]  lz_in;
    logic [63:0] sq;
    logic [32:0] sh;
    if (i == 0) begin : g_first
      assign man_in  = nrm_man_q[NORM_STEPS-1];
      assign frac_in = '0;
      assign lz_in   = nrm_lz_q[NORM_STEPS-1];
    end else begin : g_next
      assign man_in  = log_man_q[i-1];
      assign frac_in = log_frac_q[i-1];
      assign lz_in   = log_lz_q[i-1];
    end
    assign sq = man_in * man_in;
    assign sh = sq[63:31];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        log_man_q[i]  <= sh[32] ? sh[32:1] : sh[31:0];
        log_frac_q[i] <= {frac_in[26:0], sh[32]};
        log_lz_q[i]   <= lz_in;
      end
    end
  end

  assign pow_prod = len_q * cfg_i.expo;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len_q <= ((33'(log_lz_q[LOG_STEPS-1]) + 33'd1) << 28) - 33'(log_frac_q[LOG_STEPS-1]);
      pow_q <= pow_prod[48:12];
    end
  end

  for (genvar k = 0; k < EXP_STEPS; k++) begin : g_exp
    localparam logic [31:0] CK = exp_factor(k + 1);
    logic [32:0] r_in;
    logic [36:0] pw_in;
    logic [64:0] prod;
    if (k == 0) begin : g_first
      assign r_in  = 33'h1_0000_0000;
      assign pw_in = pow_q;
    end else begin : g_next
      assign r_in  = exp_r_q[k-1];
      assign pw_in = exp_pow_q[k-1];
    end
    assign prod = r_in * CK;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        exp_r_q[k]   <= pw_in[27-k] ? prod[64:32] : r_in;
        exp_pow_q[k] <= pw_in;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      priority if (flags_q[FLAG_LEN-1].zero) begin
        shaped_q <= '0;
      end else if (flags_q[FLAG_LEN-1].one) begin
        shaped_q <= 33'h1_0000_0000;
      end else if (exp_pow_q[EXP_STEPS-1][36:33] != '0) begin
        shaped_q <= '0;
      end else begin
        shaped_q <= exp_r_q[EXP_STEPS-1] >> exp_pow_q[EXP_STEPS-1][32:28];
      end
    end
  end

  assign shaped_o = shaped_q;

endmodule

[rtl/joystick_deadzone_response_core.sv]
// Two-axis stick dead zone and response curve core, top level.
// Depends on jdr_pkg, jdr_shape and assert_macros.svh.
//
// Usage:
// Samples arrive on the input channel (in_valid_i, in_ready_o, raw_x_i, raw_y_i)
// and shaped axes leave on the output channel (out_valid_o, out_ready_i, out_x_o,
// out_y_o, ok_o), one result transfer for every input transfer, in order.
// Registers are written through cfg_valid_i, cfg_index_i and cfg_data_i; the user
// must write them only while the core is idle, which the core does not enforce; cfg_ready_o is always high.
// The datapath is one pipeline with a new sample accepted in every cycle while the
// receiver does not stall, so the throughput is one sample per cycle. The bit-serial
// square root gives ROOT_W result bits (18 for the default widths).
// The depth comes from the square root, the 32-step ratio divider, the 28 log squarings
// and the 28 exp products in each shaping lane, and the radial output divider.
// Reset clears all valid bits and loads the register defaults: radial mode, no dead
// zones and a linear response.
// When the receiver stalls, the whole pipeline holds; the entry stage still takes a
// sample while it is empty, and nothing is dropped or repeated.
`include "assert_macros.svh"

module joystick_deadzone_response_core #(
  parameter int SAMPLE_BITS   = jdr_pkg::SAMPLE_BITS,
  parameter int FRACTION_BITS = jdr_pkg::FRACTION_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]     raw_x_i,
  input  logic signed [SAMPLE_BITS-1:0]     raw_y_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]     out_x_o,
  output logic signed [SAMPLE_BITS-1:0]     out_y_o,
  output logic                              ok_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [jdr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [jdr_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import jdr_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int FB     = FRACTION_BITS;
  localparam int UP     = 16 - FB;
  localparam int SQ_W   = 2 * SB;
  localparam int RAD_W  = (FB >= 16) ? (SQ_W - (2 * FB - 32)) :
                          ((2 * UP + 2 * SB <= 63) ? (SQ_W + 2 * UP) : SQ_W);
  localparam int POST   = (FB < 16 && 2 * UP + 2 * SB > 63) ? UP : 0;
  localparam int ROOT_W = (RAD_W + 1) / 2;
  localparam int CMP_W  = 2 * ROOT_W + 1;
  localparam int LEN_W  = ROOT_W + POST;
  localparam int QW     = FB + 2;
  localparam int RW     = LEN_W + 16 + QW;
  localparam int SB_LEN = 2 + ROOT_W + LANE_LAT;
  localparam int DEPTH  = ROOT_W + LANE_LAT + QW + 5;

  localparam logic signed [SB-1:0] ONE_S  = SB'(1) << FB;
  localparam logic [QW-1:0]        ONE_Q  = QW'(1) << FB;

  typedef struct packed {
    logic [SB-1:0] ax;
    logic [SB-1:0] ay;
    logic          nx;
    logic          ny;
  } side_t;

  typedef struct packed {
    logic [LEN_W-1:0] m;
    logic [FB:0]      px;
    logic [FB:0]      py;
    logic             nx;
    logic             ny;
    logic             zero;
  } post_t;

  // Configuration registers.
  logic        radial_q;
  logic [15:0] inner_q;
  logic [15:0] outer_q;
  logic [15:0] expo_q;
  logic [16:0] start;
  logic        cfg_ok;
  shape_cfg_t  shape_cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radial_q <= 1'b1;
      inner_q  <= '0;
      outer_q  <= '0;
      expo_q   <= RESET_EXPONENT;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_RADIAL_MODE: radial_q <= cfg_data_i[0];
        REG_INNER_DZ:    inner_q  <= cfg_data_i[15:0];
        REG_OUTER_DZ:    outer_q  <= cfg_data_i[15:0];
        REG_EXPONENT:    expo_q   <= cfg_data_i[15:0];
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign start       = 17'h1_0000 - {1'b0, outer_q};
  assign cfg_ok      = ({1'b0, inner_q} < start) && (expo_q != '0);
  assign shape_cfg   = {inner_q, start, expo_q};

  // Pipeline control.
  logic             vld_q [DEPTH];
  logic             en;
  logic             ld0;

  assign en          = !vld_q[DEPTH-1] || out_ready_i;
  assign ld0         = en || !vld_q[0];
  assign in_ready_o  = ld0;
  assign out_valid_o = vld_q[DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DEPTH; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      if (ld0) begin
        vld_q[0] <= in_valid_i;
      end
      if (en) begin
        for (int k = 1; k < DEPTH; k++) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Entry stage and magnitudes.
  logic [SB-1:0] rx_q;
  logic [SB-1:0] ry_q;
  side_t         sb_q [SB_LEN];
  side_t         side_in;

  always_ff @(posedge clk_i) begin
    if (ld0) begin
      rx_q <= raw_x_i;
      ry_q <= raw_y_i;
    end
  end

  always_comb begin
    side_in.nx = rx_q[SB-1];
    side_in.ny = ry_q[SB-1];
    side_in.ax = rx_q[SB-1] ? (~rx_q + 1'b1) : rx_q;
    side_in.ay = ry_q[SB-1] ? (~ry_q + 1'b1) : ry_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= side_in;
      for (int k = 1; k < SB_LEN; k++) begin
        sb_q[k] <= sb_q[k-1];
      end
    end
  end

  // Sum of squares, scaled to the radicand of the length.
  logic [SQ_W-1:0]  sqx;
  logic [SQ_W-1:0]  sqy;
  logic [SQ_W-1:0]  sqsum;
  logic [RAD_W-1:0] rad;

  assign sqx   = sb_q[0].ax * sb_q[0].ax;
  assign sqy   = sb_q[0].ay * sb_q[0].ay;
  assign sqsum = sqx + sqy;

  if (FB >= 16) begin : g_rad_down
    assign rad = RAD_W'(sqsum >> (2 * FB - 32));
  end else if (2 * UP + 2 * SB <= 63) begin : g_rad_up
    assign rad = RAD_W'(sqsum) << (2 * UP);
  end else begin : g_rad_plain
    assign rad = RAD_W'(sqsum);
  end

  // Bit-serial square root, one result bit per stage.
  logic [RAD_W-1:0]  sr_rem_q  [ROOT_W+1];
  logic [ROOT_W-1:0] sr_root_q [ROOT_W+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sr_rem_q[0]  <= rad;
      sr_root_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    localparam int B = ROOT_W - 1 - i;
    logic [CMP_W-1:0] trial;
    logic [CMP_W-1:0] rem_ext;
    logic             ge;
    assign trial   = (CMP_W'(sr_root_q[i]) << (B + 1)) | (CMP_W'(1) << (2 * B));
    assign rem_ext = CMP_W'(sr_rem_q[i]);
    assign ge      = rem_ext >= trial;
    always_ff @(posedge clk_i) begin
      if (en) begin
        sr_rem_q[i+1]  <= ge ? RAD_W'(rem_ext - trial) : sr_rem_q[i];
        sr_root_q[i+1] <= ge ? (sr_root_q[i] | (ROOT_W'(1) << B)) : sr_root_q[i];
      end
    end
  end

  // Lengths for the two shaping lanes.
  logic [LEN_W-1:0] m_rad;
  logic [LEN_W-1:0] qx16;
  logic [LEN_W-1:0] qy16;
  logic [LEN_W-1:0] len0;
  logic [LEN_W-1:0] md_q [LANE_LAT];
  side_t            side_sq;

  assign side_sq = sb_q[ROOT_W+1];
  assign m_rad   = LEN_W'(sr_root_q[ROOT_W]) << POST;

  if (FB >= 16) begin : g_q16_down
    assign qx16 = LEN_W'(side_sq.ax >> (FB - 16));
    assign qy16 = LEN_W'(side_sq.ay >> (FB - 16));
  end else begin : g_q16_up
    assign qx16 = LEN_W'(side_sq.ax) << UP;
    assign qy16 = LEN_W'(side_sq.ay) << UP;
  end

  assign len0 = radial_q ? m_rad : qx16;

  always_ff @(posedge clk_i) begin
    if (en) begin
      md_q[0] <= m_rad;
      for (int k = 1; k < LANE_LAT; k++) begin
        md_q[k] <= md_q[k-1];
      end
    end
  end

  logic [32:0] s0;
  logic [32:0] s1;

  jdr_shape #(.LEN_W(LEN_W)) u_lane_x (
    .clk_i    (clk_i),
    .en_i     (en),
    .cfg_i    (shape_cfg),
    .len_i    (len0),
    .shaped_o (s0)
  );

  jdr_shape #(.LEN_W(LEN_W)) u_lane_y (
    .clk_i    (clk_i),
    .en_i     (en),
    .cfg_i    (shape_cfg),
    .len_i    (qy16),
    .shaped_o (s1)
  );

  // Per-axis rounding and radial dividend.
  side_t            side_ln;
  logic [LEN_W-1:0] m_ln;
  logic [33+FB:0]   pax;
  logic [33+FB:0]   pay;
  logic [SB+32:0]   prodx;
  logic [SB+32:0]   prody;
  logic [RW-1:0]    numx;
  logic [RW-1:0]    numy;
  post_t            post_in;

  assign side_ln = sb_q[SB_LEN-1];
  assign m_ln    = md_q[LANE_LAT-1];
  assign pax     = ((34 + FB)'(s0) << FB) + ((34 + FB)'(1) << 31);
  assign pay     = ((34 + FB)'(s1) << FB) + ((34 + FB)'(1) << 31);
  assign prodx   = side_ln.ax * s0;
  assign prody   = side_ln.ay * s0;
  assign numx    = RW'(prodx) + (RW'(m_ln) << 15);
  assign numy    = RW'(prody) + (RW'(m_ln) << 15);

  always_comb begin
    post_in.m    = m_ln;
    post_in.px   = pax[32+FB:32];
    post_in.py   = pay[32+FB:32];
    post_in.nx   = side_ln.nx;
    post_in.ny   = side_ln.ny;
    post_in.zero = s0 == '0;
  end

  // Radial divider, one quotient bit per stage for each axis.
  post_t         pst_q  [QW+1];
  logic [RW-1:0] remx_q [QW+1];
  logic [RW-1:0] remy_q [QW+1];
  logic [QW-1:0] qx_q   [QW+1];
  logic [QW-1:0] qy_q   [QW+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      pst_q[0]  <= post_in;
      remx_q[0] <= numx;
      remy_q[0] <= numy;
      qx_q[0]   <= '0;
      qy_q[0]   <= '0;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_rdiv
    localparam int I = QW - 1 - j;
    logic [RW-1:0] dsh;
    logic          gex;
    logic          gey;
    assign dsh = RW'(pst_q[j].m) << (16 + I);
    assign gex = remx_q[j] >= dsh;
    assign gey = remy_q[j] >= dsh;
    always_ff @(posedge clk_i) begin
      if (en) begin
        pst_q[j+1]  <= pst_q[j];
        remx_q[j+1] <= gex ? (remx_q[j] - dsh) : remx_q[j];
        remy_q[j+1] <= gey ? (remy_q[j] - dsh) : remy_q[j];
        qx_q[j+1]   <= {qx_q[j][QW-2:0], gex};
        qy_q[j+1]   <= {qy_q[j][QW-2:0], gey};
      end
    end
  end

  // Output register.
  post_t         pf;
  logic [FB:0]   capx;
  logic [FB:0]   capy;
  logic [FB:0]   magx;
  logic [FB:0]   magy;
  logic [SB-1:0] out_x_d;
  logic [SB-1:0] out_y_d;
  logic [SB-1:0] out_x_q;
  logic [SB-1:0] out_y_q;
  logic          ok_q;

  assign pf   = pst_q[QW];
  assign capx = (qx_q[QW] > ONE_Q) ? ONE_Q[FB:0] : qx_q[QW][FB:0];
  assign capy = (qy_q[QW] > ONE_Q) ? ONE_Q[FB:0] : qy_q[QW][FB:0];

  always_comb begin
    if (!cfg_ok) begin
      magx = '0;
      magy = '0;
    end else if (radial_q) begin
      magx = pf.zero ? '0 : capx;
      magy = pf.zero ? '0 : capy;
    end else begin
      magx = pf.px;
      magy = pf.py;
    end
    out_x_d = pf.nx ? (~SB'(magx) + 1'b1) : SB'(magx);
    out_y_d = pf.ny ? (~SB'(magy) + 1'b1) : SB'(magy);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_x_q <= out_x_d;
      out_y_q <= out_y_d;
      ok_q    <= cfg_ok;
    end
  end

  assign out_x_o = out_x_q;
  assign out_y_o = out_y_q;
  assign ok_o    = ok_q;

  `ASSERT_RST(a_bad_cfg_zero, out_valid_o && !ok_o |-> out_x_o == '0 && out_y_o == '0, "output not zero with invalid settings")
  `ASSERT_ALW(a_x_range, out_valid_o |-> out_x_o <= ONE_S && out_x_o >= -ONE_S, "out_x magnitude above one")
  `ASSERT_ALW(a_y_range, out_valid_o |-> out_y_o <= ONE_S && out_y_o >= -ONE_S, "out_y magnitude above one")
  `ASSERT_RST(a_stall_cause, in_valid_i && !in_ready_o |-> vld_q[0] && out_valid_o && !out_ready_i, "input stalled without a full pipeline")
  `ASSERT_RST(a_ok_matches, out_valid_o |-> ok_o == cfg_ok, "ok flag differs from settings")

endmodule
